FILE: rtl/core/tafl_pkg.sv
package tafl_pkg;

  localparam int COEF_W    = 16;
  localparam int NUM_COEF  = 7;
  localparam int FRAC_BITS = 15;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COEF_W;

  // Register index of the last coefficient; writes above it are dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_LAST = CFG_IDX_W'(NUM_COEF - 1);

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef coef_t [NUM_COEF-1:0] coef_arr_t;

  // Symmetric low-pass taps in Q1.15, listed from the oldest tap down to the newest.
  localparam coef_arr_t COEF_RESET = {
    16'sd993, 16'sd3890, 16'sd7186, 16'sd8638, 16'sd7186, 16'sd3890, 16'sd993
  };

endpackage

FILE: rtl/core/tafl_if.sv
interface tafl_in_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_x;
  logic signed [SAMPLE_WIDTH-1:0] sample_y;
  logic signed [SAMPLE_WIDTH-1:0] sample_z;

  modport source(output valid, output sample_x, output sample_y, output sample_z,
                 input ready);
  modport sink(input valid, input sample_x, input sample_y, input sample_z,
               output ready);
endinterface

interface tafl_out_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] filt_x;
  logic signed [SAMPLE_WIDTH-1:0] filt_y;
  logic signed [SAMPLE_WIDTH-1:0] filt_z;

  modport source(output valid, output filt_x, output filt_y, output filt_z,
                 input ready);
  modport sink(input valid, input filt_x, input filt_y, input filt_z,
               output ready);
endinterface

FILE: rtl/core/tafl_coef_regs.sv
module tafl_coef_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [tafl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tafl_pkg::CFG_DATA_W-1:0] cfg_data,
  output tafl_pkg::coef_arr_t            coef
);
  import tafl_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= COEF_RESET;
    end else if (cfg_we && (cfg_index <= CFG_COEF_LAST)) begin
      coef[cfg_index] <= coef_t'(cfg_data);
    end
  end

endmodule

FILE: rtl/core/tafl_axis.sv
module tafl_axis #(
  parameter int ORDER        = 6,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           load,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  tafl_pkg::coef_arr_t            coef,
  output logic signed [SAMPLE_WIDTH-1:0] result
);
  import tafl_pkg::*;

  localparam int TAPS   = ORDER + 1;
  localparam int PROD_W = SAMPLE_WIDTH + COEF_W;
  localparam int ACC_W  = PROD_W + $clog2(TAPS + 1);

  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] SMAX = ACC_W'((1 << (SAMPLE_WIDTH - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SMIN = -SMAX - ACC_W'(1);

  logic signed [SAMPLE_WIDTH-1:0] hist [ORDER];
  logic signed [SAMPLE_WIDTH-1:0] tap  [TAPS];
  logic signed [PROD_W-1:0]       prod [TAPS];
  logic signed [PROD_W-1:0]       prod_q [TAPS];
  logic signed [ACC_W-1:0]        acc;
  logic signed [ACC_W-1:0]        rounded;
  logic signed [ACC_W-1:0]        scaled;

  // Only the taps in use are kept; deeper history could never reach the output.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < ORDER; k++) begin
        hist[k] <= '0;
      end
    end else if (load) begin
      hist[0] <= sample;
      for (int k = 1; k < ORDER; k++) begin
        hist[k] <= hist[k-1];
      end
    end
  end

  always_comb begin
    tap[0] = sample;
    for (int k = 1; k < TAPS; k++) begin
      tap[k] = hist[k-1];
    end
    for (int k = 0; k < TAPS; k++) begin
      prod[k] = PROD_W'($signed(coef[k]) * tap[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prod_q <= prod;
    end
  end

  // Round half up, then an arithmetic shift gives the floor of the scaled sum.
  always_comb begin
    acc = '0;
    for (int k = 0; k < TAPS; k++) begin
      acc = acc + ACC_W'(prod_q[k]);
    end
    rounded = acc + HALF;
    scaled  = rounded >>> FRAC_BITS;
    if (scaled > SMAX) begin
      result = SMAX[SAMPLE_WIDTH-1:0];
    end else if (scaled < SMIN) begin
      result = SMIN[SAMPLE_WIDTH-1:0];
    end else begin
      result = scaled[SAMPLE_WIDTH-1:0];
    end
  end

endmodule

FILE: rtl/core/three_axis_fir_lowpass.sv
// Three-axis seven-tap FIR low-pass filter. Each beat on sample_in carries one
// signed sample per axis and produces exactly one beat on filt_out with the
// filtered value of each axis, rounded to nearest (ties up) and saturated to
// SAMPLE_WIDTH bits. The block takes one sample triple per clock cycle while
// filt_out does not stall. The per-tap multiplies run in the cycle a sample
// beat is accepted and land in a product register. From there the adders,
// rounding and saturation fill the output register, which drives filt_out,
// and filt_out.valid rises once that register is loaded. While filt_out
// stalls, sample_in stays ready until the product stage also holds a beat.
// Coefficients are Q1.15; the user must write them through the cfg port while
// the block is idle, and the block itself does not enforce it.
module three_axis_fir_lowpass #(
  parameter int ORDER        = 6,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  tafl_in_if.sink                         sample_in,
  tafl_out_if.source                      filt_out,
  input  logic                            cfg_we,
  input  logic [tafl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tafl_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tafl_pkg::*;

  coef_arr_t                      coef;
  logic                           prod_valid;
  logic                           out_valid;
  logic                           out_load;
  logic                           in_load;
  logic signed [SAMPLE_WIDTH-1:0] res_x;
  logic signed [SAMPLE_WIDTH-1:0] res_y;
  logic signed [SAMPLE_WIDTH-1:0] res_z;

  assign out_load        = prod_valid && (!out_valid || filt_out.ready);
  assign sample_in.ready = !prod_valid || out_load;
  assign in_load         = sample_in.valid && sample_in.ready;

  tafl_coef_regs u_coef (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef      (coef)
  );

  tafl_axis #(.ORDER(ORDER), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_axis_x (
    .clk    (clk),
    .rst    (rst),
    .load   (in_load),
    .sample (sample_in.sample_x),
    .coef   (coef),
    .result (res_x)
  );

  tafl_axis #(.ORDER(ORDER), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_axis_y (
    .clk    (clk),
    .rst    (rst),
    .load   (in_load),
    .sample (sample_in.sample_y),
    .coef   (coef),
    .result (res_y)
  );

  tafl_axis #(.ORDER(ORDER), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_axis_z (
    .clk    (clk),
    .rst    (rst),
    .load   (in_load),
    .sample (sample_in.sample_z),
    .coef   (coef),
    .result (res_z)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_load) begin
        prod_valid <= 1'b1;
      end else if (out_load) begin
        prod_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (filt_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      filt_out.filt_x <= res_x;
      filt_out.filt_y <= res_y;
      filt_out.filt_z <= res_z;
    end
  end

  assign filt_out.valid = out_valid;

endmodule

FILE: rtl/core/tafl_checker.sv
module tafl_checker #(
  parameter int SAMPLE_WIDTH = 16
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [SAMPLE_WIDTH-1:0] filt_x,
  input logic [SAMPLE_WIDTH-1:0] filt_y,
  input logic [SAMPLE_WIDTH-1:0] filt_z
);

  // A result beat only appears after a sample beat was taken.
  a_out_follows_in: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result beat without a matching sample beat");

  // With the output side free, the filter never holds off the sensor.
  a_ready_when_free: assert property (@(posedge clk)
    (!out_valid || out_ready) |-> in_ready)
    else $error("sample_in not ready while filt_out can drain");

  a_out_valid_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_data_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> ($stable(filt_x) && $stable(filt_y) && $stable(filt_z)))
    else $error("result changed while stalled");

endmodule

bind three_axis_fir_lowpass tafl_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_tafl_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (sample_in.valid),
  .in_ready  (sample_in.ready),
  .out_valid (filt_out.valid),
  .out_ready (filt_out.ready),
  .filt_x    (filt_out.filt_x),
  .filt_y    (filt_out.filt_y),
  .filt_z    (filt_out.filt_z)
);
